// ===== hw/rtl/rfl_pkg.sv =====
// Shared types, codes and constants for the register free list allocator.
// Used by rfl_free_list, rfl_map_table and register_free_list_allocator.
package rfl_pkg;

	localparam int REQ_W    = 3;
	localparam int VREG_W   = 8;
	localparam int PREG_W   = 5;
	localparam int STATUS_W = 2;
	localparam int MASK_W   = 32;

	localparam int NUM_PREGS = 1 << PREG_W;
	localparam int VREG_SPAN = 1 << VREG_W;

	localparam int VIRTUAL_REGS_DEF = 256;
	localparam int FREE_DEPTH_DEF   = 32;

	// Number of entries the free list holds out of reset.
	localparam int RESET_COUNT = 13;

	// Registers 3, 6, 7, 8..15, 24 and 25 form the allocatable pool.
	localparam logic [MASK_W-1:0] POOL_MASK = 32'h0300_FFC8;

	typedef enum logic [REQ_W-1:0] {
		REQ_MAP       = 3'd0,
		REQ_FREE_VIRT = 3'd1,
		REQ_FREE_TEMP = 3'd2,
		REQ_TAKE_TEMP = 3'd3,
		REQ_ADD_MAP   = 3'd4,
		REQ_QUERY     = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_UNMAPPED = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SORT,
		ST_EXEC
	} fsm_state_t;

	// Contents of a free list entry that has not been written since reset.
	function automatic logic [PREG_W-1:0] reset_entry(input int unsigned idx);
		logic [PREG_W-1:0] val;
		unique case (idx)
			0, 1, 2, 3, 4, 5, 6, 7: val = PREG_W'(idx + 8);
			8:       val = PREG_W'(3);
			9:       val = PREG_W'(6);
			10:      val = PREG_W'(7);
			11:      val = PREG_W'(24);
			12:      val = PREG_W'(25);
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== hw/rtl/rfl_free_list.sv =====
// Free list storage: a synchronous single-port-read, single-port-write memory
// with per-entry written flags so that unwritten entries read as reset contents.
// Depends on rfl_pkg.
module rfl_free_list #(
	parameter int DEPTH = rfl_pkg::FREE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [rfl_pkg::PREG_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [rfl_pkg::PREG_W-1:0] wr_data
);
	import rfl_pkg::*;

	logic [PREG_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  written_q;
	logic [PREG_W-1:0] rd_raw_q;
	logic [AW-1:0]     rd_addr_q;
	logic              rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : reset_entry(int'(rd_addr_q));

endmodule

// ===== hw/rtl/rfl_map_table.sv =====
// Virtual to physical map: target memory with a registered read, plus
// mapped flags that reset clears. Depends on rfl_pkg.
module rfl_map_table #(
	parameter int DEPTH = rfl_pkg::VIRTUAL_REGS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic                       rd_valid,
	output logic [rfl_pkg::PREG_W-1:0] rd_target,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic                       wr_valid,
	input  logic [rfl_pkg::PREG_W-1:0] wr_target
);
	import rfl_pkg::*;

	logic [PREG_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  mapped_q;
	logic [PREG_W-1:0] rd_target_q;
	logic              rd_valid_q;

	// A free only clears the flag; the stale target is never used again.
	always_ff @(posedge clk) begin
		if (wr_en && wr_valid) begin
			mem[wr_addr] <= wr_target;
		end
		if (rd_en) begin
			rd_target_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				mapped_q[wr_addr] <= wr_valid;
			end
			if (rd_en) begin
				rd_valid_q <= mapped_q[rd_addr];
			end
		end
	end

	assign rd_valid  = rd_valid_q;
	assign rd_target = rd_target_q;

endmodule

// ===== hw/rtl/register_free_list_allocator.sv =====
// Physical register allocator with a FIFO free list and a virtual register map.
// Map, free, take and add requests: memories read at accept, result registered
// on execute, which waits while an untaken result holds the output; the next
// request is accepted only after the previous one executes. Query: a scan over
// the list, then a sorted write back over all 32 register numbers. Reset clears
// the map flags at once and restores the initial free list; no clearing pass.
module register_free_list_allocator #(
	parameter int VIRTUAL_REGS = rfl_pkg::VIRTUAL_REGS_DEF,
	parameter int FREE_DEPTH   = rfl_pkg::FREE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rfl_pkg::REQ_W-1:0]    req_type,
	input  logic [rfl_pkg::VREG_W-1:0]   virtual_reg,
	input  logic [rfl_pkg::PREG_W-1:0]   phys_reg,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rfl_pkg::PREG_W-1:0]   granted_reg,
	output logic [rfl_pkg::STATUS_W-1:0] status,
	output logic [rfl_pkg::MASK_W-1:0]   used_mask
);
	import rfl_pkg::*;

	localparam int MAP_DEPTH = (VIRTUAL_REGS < VREG_SPAN) ? VIRTUAL_REGS : VREG_SPAN;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int IDX_W     = $clog2(FREE_DEPTH);
	localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
	localparam int SUM_W     = IDX_W + 1;

	// Virtual register numbers wrap modulo the map size.
	logic [MAP_AW-1:0] vr_mod_tbl [VREG_SPAN];
	for (genvar gi = 0; gi < VREG_SPAN; gi++) begin : g_vr_mod
		assign vr_mod_tbl[gi] = MAP_AW'(gi % VIRTUAL_REGS);
	end

	fsm_state_t state_q, state_d;

	logic [REQ_W-1:0]  req_s1;
	logic [MAP_AW-1:0] vr_s1;
	logic [PREG_W-1:0] pr_s1;

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_i_q;
	logic              scan_pend_q;
	logic [MASK_W-1:0] present_q;
	logic [CNT_W-1:0]  tally_q [NUM_PREGS];
	logic [PREG_W-1:0] sort_v_q;
	logic [IDX_W-1:0]  sort_pos_q;

	logic              out_valid_q;
	logic [PREG_W-1:0] granted_q;
	status_t           status_q;
	logic [MASK_W-1:0] mask_q;

	// Memory ports.
	logic              fl_rd_en, fl_wr_en;
	logic [IDX_W-1:0]  fl_rd_addr, fl_wr_addr;
	logic [PREG_W-1:0] fl_rd_data, fl_wr_data;
	logic              map_rd_en, map_wr_en;
	logic              map_rd_valid;
	logic [PREG_W-1:0] map_rd_target;

	// Control terms.
	logic              accept, exec_fire, scan_issue, sort_wr, sort_end;
	logic              list_full, list_empty;
	logic [CNT_W-1:0]  tally_cur;
	logic [SUM_W-1:0]  tail_sum, scan_sum;
	logic [IDX_W-1:0]  tail_idx, scan_idx, head_inc;

	// Outcome of the request held in stage one.
	logic              ex_pop, ex_push, ex_map_wr, ex_map_valid;
	logic [PREG_W-1:0] ex_push_val, ex_map_tgt, ex_granted;
	status_t           ex_status;
	logic [MASK_W-1:0] ex_mask;

	rfl_free_list #(
		.DEPTH (FREE_DEPTH),
		.AW    (IDX_W)
	) u_free_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (fl_rd_en),
		.rd_addr (fl_rd_addr),
		.rd_data (fl_rd_data),
		.wr_en   (fl_wr_en),
		.wr_addr (fl_wr_addr),
		.wr_data (fl_wr_data)
	);

	rfl_map_table #(
		.DEPTH (MAP_DEPTH),
		.AW    (MAP_AW)
	) u_map_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (map_rd_en),
		.rd_addr   (vr_mod_tbl[virtual_reg]),
		.rd_valid  (map_rd_valid),
		.rd_target (map_rd_target),
		.wr_en     (map_wr_en),
		.wr_addr   (vr_s1),
		.wr_valid  (ex_map_valid),
		.wr_target (ex_map_tgt)
	);

	// Circular list arithmetic; every sum stays below twice the depth.
	assign list_full  = (count_q == CNT_W'(FREE_DEPTH));
	assign list_empty = (count_q == '0);
	assign tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
	assign scan_sum   = SUM_W'(head_q) + SUM_W'(scan_i_q);
	assign tail_idx   = (tail_sum >= SUM_W'(FREE_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(FREE_DEPTH)) : IDX_W'(tail_sum);
	assign scan_idx   = (scan_sum >= SUM_W'(FREE_DEPTH)) ?
		IDX_W'(scan_sum - SUM_W'(FREE_DEPTH)) : IDX_W'(scan_sum);
	assign head_inc   = (head_q == IDX_W'(FREE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign tally_cur  = tally_q[sort_v_q];

	always_comb begin
		ex_pop       = 1'b0;
		ex_push      = 1'b0;
		ex_push_val  = pr_s1;
		ex_map_wr    = 1'b0;
		ex_map_valid = 1'b0;
		ex_map_tgt   = pr_s1;
		ex_granted   = '0;
		ex_status    = STAT_OK;
		ex_mask      = '0;
		unique case (req_s1)
			REQ_MAP: begin
				if (map_rd_valid) begin
					ex_granted = map_rd_target;
				end else if (!list_empty) begin
					ex_pop       = 1'b1;
					ex_granted   = fl_rd_data;
					ex_map_wr    = 1'b1;
					ex_map_valid = 1'b1;
					ex_map_tgt   = fl_rd_data;
				end else begin
					ex_status = STAT_EMPTY;
				end
			end
			REQ_FREE_VIRT: begin
				if (!map_rd_valid) begin
					ex_status = STAT_UNMAPPED;
				end else if (list_full) begin
					ex_status = STAT_OVERFLOW;
				end else begin
					ex_push     = 1'b1;
					ex_push_val = map_rd_target;
					ex_map_wr   = 1'b1;
				end
			end
			REQ_FREE_TEMP: begin
				if (list_full) begin
					ex_status = STAT_OVERFLOW;
				end else begin
					ex_push = 1'b1;
				end
			end
			REQ_TAKE_TEMP: begin
				if (!list_empty) begin
					ex_pop     = 1'b1;
					ex_granted = fl_rd_data;
				end else begin
					ex_status = STAT_EMPTY;
				end
			end
			REQ_ADD_MAP: begin
				ex_map_wr    = 1'b1;
				ex_map_valid = 1'b1;
			end
			REQ_QUERY: begin
				ex_mask = POOL_MASK & ~present_q;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_QUERY) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				if (!scan_issue && !scan_pend_q) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (sort_end) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs and memory port selection.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		accept     = in_ready && in_valid;
		scan_issue = (state_q == ST_SCAN) && (scan_i_q != count_q);
		sort_wr    = (state_q == ST_SORT) && (tally_cur != '0);
		sort_end   = (state_q == ST_SORT) && (tally_cur == '0) &&
			(sort_v_q == PREG_W'(NUM_PREGS - 1));
		exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

		map_rd_en = accept;
		map_wr_en = exec_fire && ex_map_wr;

		fl_rd_en   = accept || scan_issue;
		fl_rd_addr = (state_q == ST_SCAN) ? scan_idx : head_q;
		fl_wr_en   = sort_wr || (exec_fire && ex_push);
		fl_wr_addr = (state_q == ST_SORT) ? sort_pos_q : tail_idx;
		fl_wr_data = (state_q == ST_SORT) ? sort_v_q : ex_push_val;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			vr_s1  <= vr_mod_tbl[virtual_reg];
			pr_s1  <= phys_reg;
		end
		if (exec_fire) begin
			granted_q <= ex_granted;
			status_q  <= ex_status;
			mask_q    <= ex_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= CNT_W'(RESET_COUNT);
			scan_i_q    <= '0;
			scan_pend_q <= 1'b0;
			present_q   <= '0;
			sort_v_q    <= '0;
			sort_pos_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PREGS; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (accept) begin
				scan_i_q   <= '0;
				present_q  <= '0;
				sort_v_q   <= '0;
				sort_pos_q <= '0;
			end

			// The scan histograms the list; the tallies drain back to zero in the sort.
			scan_pend_q <= scan_issue;
			if (scan_issue) begin
				scan_i_q <= scan_i_q + CNT_W'(1);
			end
			if (scan_pend_q) begin
				tally_q[fl_rd_data]   <= tally_q[fl_rd_data] + CNT_W'(1);
				present_q[fl_rd_data] <= 1'b1;
			end

			if (sort_wr) begin
				tally_q[sort_v_q] <= tally_cur - CNT_W'(1);
				sort_pos_q        <= sort_pos_q + IDX_W'(1);
			end else if ((state_q == ST_SORT) && !sort_end) begin
				sort_v_q <= sort_v_q + PREG_W'(1);
			end

			if (sort_end) begin
				head_q <= '0;
			end else if (exec_fire && ex_pop) begin
				head_q <= head_inc;
			end

			if (exec_fire && ex_pop) begin
				count_q <= count_q - CNT_W'(1);
			end else if (exec_fire && ex_push) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign granted_reg = granted_q;
	assign status      = status_q;
	assign used_mask   = mask_q;

	logic tally_any;
	always_comb begin
		tally_any = 1'b0;
		for (int i = 0; i < NUM_PREGS; i++) begin
			tally_any = tally_any | (tally_q[i] != '0);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FREE_DEPTH))
		else $error("free list count exceeds its depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(head_q) < SUM_W'(FREE_DEPTH))
		else $error("free list head outside the list");

	a_tally_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !tally_any)
		else $error("sort left tallies behind");

	a_sort_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sort_wr |-> (SUM_W'(sort_pos_q) < SUM_W'(FREE_DEPTH)))
		else $error("sorted write back runs past the list");

	a_query_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && (req_s1 == REQ_QUERY)) |-> (head_q == '0))
		else $error("query finished without rewinding the head");

endmodule

// ===== tb/tb_register_free_list_allocator.sv =====
// Self-checking testbench for register_free_list_allocator: predicts every
// result word and compares it with the block's output. Depends on rfl_pkg.
module tb_register_free_list_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import rfl_pkg::*;

	localparam int VIRTUAL_REGS = VIRTUAL_REGS_DEF;
	localparam int FREE_DEPTH   = FREE_DEPTH_DEF;

	// Request codes with no operation behind them.
	localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1530;
	localparam int BLOCK_LEN    = 60;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 200;
	localparam int PAUSE_AT     = 700;
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1150;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [PREG_W-1:0] BOOT_LIST [RESET_COUNT] =
		'{8, 9, 10, 11, 12, 13, 14, 15, 3, 6, 7, 24, 25};

	typedef enum {MIX_BALANCED, MIX_DRAIN, MIX_FILL} mix_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [VREG_W-1:0] vreg;
		logic [PREG_W-1:0] preg;
	} alloc_req_t;

	typedef struct packed {
		logic [PREG_W-1:0] granted;
		status_t           stat;
		logic [MASK_W-1:0] mask;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [REQ_W-1:0]    req_type = '0;
	logic [VREG_W-1:0]   virtual_reg = '0;
	logic [PREG_W-1:0]   phys_reg = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [PREG_W-1:0]   granted_reg;
	logic [STATUS_W-1:0] status;
	logic [MASK_W-1:0]   used_mask;

	register_free_list_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.virtual_reg (virtual_reg),
		.phys_reg    (phys_reg),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.granted_reg (granted_reg),
		.status      (status),
		.used_mask   (used_mask)
	);

	// Shadow copy of the allocator state.
	logic [PREG_W-1:0] fl_entries [FREE_DEPTH];
	int unsigned       fl_head;
	int unsigned       fl_count;
	bit                vmap_valid [VIRTUAL_REGS];
	logic [PREG_W-1:0] vmap_phys [VIRTUAL_REGS];

	alloc_req_t  request_backlog [$];
	grant_t      pending_grants [$];
	bit          in_taken;
	bit          out_taken;
	int unsigned requests_taken = 0;
	int unsigned grants_checked = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	logic        calm;

	assign calm = grants_checked >= CALM_FROM && grants_checked < CALM_TO;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit pop_free(output logic [PREG_W-1:0] p);
		p = '0;
		if (fl_count == 0)
			return 1'b0;
		p = fl_entries[fl_head];
		fl_head = (fl_head + 1) % FREE_DEPTH;
		fl_count--;
		return 1'b1;
	endfunction

	function automatic bit push_free(input logic [PREG_W-1:0] p);
		if (fl_count >= FREE_DEPTH)
			return 1'b0;
		fl_entries[(fl_head + fl_count) % FREE_DEPTH] = p;
		fl_count++;
		return 1'b1;
	endfunction

	function automatic grant_t predict_grant(input alloc_req_t it);
		grant_t            r;
		int unsigned       v;
		int unsigned       slot;
		int unsigned       tally [NUM_PREGS];
		logic [MASK_W-1:0] present;
		logic [PREG_W-1:0] p;
		r.granted = '0;
		r.stat = STAT_OK;
		r.mask = '0;
		v = it.vreg % VIRTUAL_REGS;
		case (it.req)
			REQ_MAP: begin
				if (vmap_valid[v]) begin
					r.granted = vmap_phys[v];
				end else if (pop_free(p)) begin
					vmap_valid[v] = 1'b1;
					vmap_phys[v] = p;
					r.granted = p;
				end else begin
					r.stat = STAT_EMPTY;
				end
			end
			REQ_FREE_VIRT: begin
				if (!vmap_valid[v])
					r.stat = STAT_UNMAPPED;
				else if (push_free(vmap_phys[v]))
					vmap_valid[v] = 1'b0;
				else
					r.stat = STAT_OVERFLOW;
			end
			REQ_FREE_TEMP: begin
				if (!push_free(it.preg))
					r.stat = STAT_OVERFLOW;
			end
			REQ_TAKE_TEMP: begin
				if (pop_free(p))
					r.granted = p;
				else
					r.stat = STAT_EMPTY;
			end
			REQ_ADD_MAP: begin
				vmap_valid[v] = 1'b1;
				vmap_phys[v] = it.preg;
			end
			REQ_QUERY: begin
				// Count every held entry, then rewrite the list in ascending order
				// from entry zero, keeping duplicates.
				present = '0;
				tally = '{default: 0};
				for (int i = 0; i < fl_count; i++) begin
					p = fl_entries[(fl_head + i) % FREE_DEPTH];
					tally[p]++;
					present[p] = 1'b1;
				end
				slot = 0;
				for (int n = 0; n < NUM_PREGS; n++)
					for (int k = 0; k < tally[n]; k++) begin
						fl_entries[slot] = PREG_W'(n);
						slot++;
					end
				fl_head = 0;
				r.mask = POOL_MASK & ~present;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] r, input logic [VREG_W-1:0] v,
			input logic [PREG_W-1:0] p);
		request_backlog.insert(request_backlog.size(), alloc_req_t'{req: r, vreg: v, preg: p});
	endtask

	// Input side: a new word is offered only once the previous one was taken.
	always @(negedge clk) begin : feed_requests
		alloc_req_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (request_backlog.size() != 0
					&& !(requests_taken == PAUSE_AT && pending_grants.size() != 0)
					&& (calm || $urandom_range(99) >= 17)) begin
				nxt = request_backlog[0];
				request_backlog.delete(0);
				in_valid <= 1'b1;
				req_type <= nxt.req;
				virtual_reg <= nxt.vreg;
				phys_reg <= nxt.preg;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side, with one long hold-off so that the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (!hold_done && grants_checked >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 17;
			end
		end
	end

	always @(posedge clk) begin : check_grants
		grant_t want;
		in_taken = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		if (out_taken) begin
			grants_checked++;
			if (pending_grants.size() == 0) begin
				mismatches++;
				$display("%0t: expected no word, actual granted_reg %0d status %0d used_mask %h",
					$time, granted_reg, status, used_mask);
			end else begin
				want = pending_grants[0];
				pending_grants.delete(0);
				if (granted_reg !== want.granted) begin
					mismatches++;
					$display("%0t: granted_reg expected %0d actual %0d",
						$time, want.granted, granted_reg);
				end
				if (status !== want.stat) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time, want.stat, status);
				end
				if (used_mask !== want.mask) begin
					mismatches++;
					$display("%0t: used_mask expected %h actual %h",
						$time, want.mask, used_mask);
				end
			end
		end
		if (in_taken) begin
			pending_grants.insert(pending_grants.size(), predict_grant(alloc_req_t'{
				req: req_type, vreg: virtual_reg, preg: phys_reg}));
			requests_taken++;
		end
		if (in_taken || out_taken)
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		mix_t        mix;
		int unsigned roll;
		int unsigned total;
		int unsigned cut [6];
		logic [REQ_W-1:0] r;

		for (int i = 0; i < FREE_DEPTH; i++)
			fl_entries[i] = (i < RESET_COUNT) ? BOOT_LIST[i] : '0;
		fl_head = 0;
		fl_count = RESET_COUNT;
		for (int i = 0; i < VIRTUAL_REGS; i++) begin
			vmap_valid[i] = 1'b0;
			vmap_phys[i] = '0;
		end

		// Directed part: every operation, both ends of the fields, remapping,
		// unmapped frees, duplicate entries and the two reserved codes.
		queue_req(REQ_QUERY, 8'd0, 5'd0);
		queue_req(REQ_MAP, 8'd0, 5'd0);
		queue_req(REQ_MAP, 8'd0, 5'd31);
		queue_req(REQ_MAP, 8'd255, 5'd0);
		queue_req(REQ_FREE_VIRT, 8'd0, 5'd0);
		queue_req(REQ_FREE_VIRT, 8'd0, 5'd31);
		queue_req(REQ_FREE_VIRT, 8'd128, 5'd0);
		queue_req(REQ_ADD_MAP, 8'd200, 5'd31);
		queue_req(REQ_ADD_MAP, 8'd200, 5'd0);
		queue_req(REQ_MAP, 8'd200, 5'd17);
		queue_req(REQ_FREE_VIRT, 8'd200, 5'd0);
		queue_req(REQ_FREE_TEMP, 8'd0, 5'd31);
		queue_req(REQ_TAKE_TEMP, 8'd255, 5'd31);
		queue_req(REQ_RSVD_LO, 8'd255, 5'd31);
		queue_req(REQ_RSVD_HI, 8'd170, 5'd21);
		queue_req(REQ_QUERY, 8'd85, 5'd10);
		queue_req(REQ_ADD_MAP, 8'd85, 5'd10);
		queue_req(REQ_FREE_VIRT, 8'd85, 5'd0);
		queue_req(REQ_FREE_TEMP, 8'd0, 5'd10);
		queue_req(REQ_QUERY, 8'd0, 5'd0);
		queue_req(REQ_FREE_VIRT, 8'd255, 5'd0);
		queue_req(REQ_TAKE_TEMP, 8'd0, 5'd0);
		queue_req(REQ_MAP, 8'd1, 5'd0);

		// Random part in blocks that lean toward draining or filling the list,
		// so that both the empty and the full list are reached repeatedly.
		mix = MIX_DRAIN;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_LEN == 0) begin
				if (n / BLOCK_LEN == 0)
					mix = MIX_DRAIN;
				else if (n / BLOCK_LEN == 1)
					mix = MIX_FILL;
				else
					mix = mix_t'($urandom_range(2));
				case (mix)
					MIX_DRAIN: cut = '{40, 45, 50, 90, 95, 99};
					MIX_FILL:  cut = '{8, 28, 88, 92, 96, 99};
					default:   cut = '{32, 54, 70, 85, 95, 99};
				endcase
			end
			roll = $urandom_range(99);
			if (roll < cut[0])
				r = REQ_MAP;
			else if (roll < cut[1])
				r = REQ_FREE_VIRT;
			else if (roll < cut[2])
				r = REQ_FREE_TEMP;
			else if (roll < cut[3])
				r = REQ_TAKE_TEMP;
			else if (roll < cut[4])
				r = REQ_ADD_MAP;
			else if (roll < cut[5])
				r = REQ_QUERY;
			else
				r = $urandom_range(1) ? REQ_RSVD_HI : REQ_RSVD_LO;
			// Mostly a small set of virtual registers, so frees find mappings.
			queue_req(r, ($urandom_range(99) < 70) ? VREG_W'($urandom_range(15))
				: VREG_W'($urandom_range(255)), PREG_W'($urandom_range(31)));
		end
		total = request_backlog.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_taken != total)
			@(posedge clk);
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_grants.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== register_free_list_allocator.f =====
hw/rtl/rfl_pkg.sv
hw/rtl/rfl_free_list.sv
hw/rtl/rfl_map_table.sv
hw/rtl/register_free_list_allocator.sv
tb/tb_register_free_list_allocator.sv
